// ----- rtl/hxc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hxc_pkg
// Shared types, formats and matrix constants of the HSL / XYZ color converter.
// ----------------------------------------------------------------------------
package hxc_pkg;

  // Fixed-point formats
  localparam int FRAC_BITS     = 15;
  localparam int HUE_FRAC_BITS = 6;
  localparam int CBITS         = 16;
  localparam int XW            = FRAC_BITS + 2;
  localparam int SW            = FRAC_BITS + 1;
  localparam int HW            = 9 + HUE_FRAC_BITS;

  localparam int ONE    = 1 << FRAC_BITS;
  localparam int DEG60  = 60 << HUE_FRAC_BITS;
  localparam int DEG360 = 360 << HUE_FRAC_BITS;
  localparam int XMAX   = (1 << XW) - 1;

  // Divider sizing
  localparam int DEG60_W = $clog2(DEG60 + 1);
  localparam int HNUM_W  = SW + DEG60_W + 1;
  localparam int SNUM_W  = 2 * FRAC_BITS + 1;
  localparam int DIV_NW  = (SNUM_W > HNUM_W) ? SNUM_W : HNUM_W;
  localparam int DIV_DW  = (SW > DEG60_W) ? SW : DEG60_W;

  // Divider lanes
  localparam int LANES    = 2;
  localparam int LANE_SAT = 0;
  localparam int LANE_HUE = 1;

  // Ramp division by sixty degrees, which is 15 << (HUE_FRAC_BITS + 2):
  // shift out the power of two, then divide by 15 with a reciprocal multiply
  localparam int CP_W    = SW + DEG60_W;
  localparam int RCP_PRE = HUE_FRAC_BITS + 2;
  localparam int RCP_XW  = CP_W - RCP_PRE;
  localparam int RCP_SH  = FRAC_BITS + 9;
  localparam int RCP_MW  = RCP_SH - 3;
  localparam int RCP_PW  = RCP_XW + RCP_MW;
  localparam logic [RCP_MW-1:0] RCP_MUL =
    RCP_MW'(((64'd1 << RCP_SH) + 64'd14) / 64'd15);

  // Matrix product widths
  localparam int COEF_W = 19;
  localparam int RP_W   = COEF_W + XW + 1;
  localparam int RA_W   = RP_W + 2;
  localparam int XP_W   = CBITS + SW;
  localparam int XA_W   = XP_W + 2;

  // XYZ to linear RGB, Q2.16 signed
  localparam logic signed [COEF_W-1:0] TO_RGB [3][3] = '{
    '{ 19'sd200751, -19'sd91313, -19'sd31182},
    '{-19'sd63520,   19'sd122943, 19'sd2723},
    '{ 19'sd4448,   -19'sd14997,  19'sd70074}
  };

  // Linear RGB to XYZ, Q0.16 unsigned
  localparam logic [CBITS-1:0] TO_XYZ [3][3] = '{
    '{16'd28218, 16'd22384, 16'd11687},
    '{16'd14550, 16'd46311, 16'd4675},
    '{16'd1323,  16'd8490,  16'd61550}
  };

  typedef enum logic [1:0] {
    RAMP_RISE,
    RAMP_HIGH,
    RAMP_LOW
  } hxc_ramp_e;

  typedef enum logic [1:0] {
    SECT_RED,
    SECT_GREEN,
    SECT_BLUE
  } hxc_sect_e;

  typedef struct packed {
    logic          mode;
    logic [XW-1:0] in_x;
    logic [XW-1:0] in_y;
    logic [XW-1:0] in_z;
    logic [HW-1:0] in_hue;
    logic [SW-1:0] in_sat;
    logic [SW-1:0] in_light;
  } hxc_req_t;

  typedef struct packed {
    logic [HW-1:0] out_hue;
    logic [SW-1:0] out_sat;
    logic [SW-1:0] out_light;
    logic [XW-1:0] out_x;
    logic [XW-1:0] out_y;
    logic [XW-1:0] out_z;
    logic          range_error;
  } hxc_rsp_t;

  // Context that travels alongside the divider
  typedef struct packed {
    logic          mode;
    logic          range_error;
    logic          gray;
    hxc_sect_e     sector;
    logic          neg;
    logic [SW-1:0] light;
    logic [SW-1:0] ch0;
    logic [SW-1:0] ch1;
    logic [SW-1:0] ch2;
  } hxc_mid_t;

endpackage
`default_nettype wire

// ----- rtl/hxc_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hxc_front
// Five pipeline stages ahead of the divider: XYZ to clamped RGB, channel
// extremes and divider operands in one direction; range check, ramp values,
// per-channel hue sectors and the ramp channel values in the other.
// ----------------------------------------------------------------------------
module hxc_front import hxc_pkg::*; (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                en_i,
  input  wire                valid_i,
  input  hxc_req_t           req_i,
  output logic               valid_o,
  output hxc_mid_t           mid_o,
  output logic [DIV_NW-1:0]  num_o [LANES],
  output logic [DIV_DW-1:0]  den_o [LANES]
);

  logic v1_q, v2_q, v3_q, v4_q, v5_q;

  // Advance the valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  // ---------------- stage 1: matrix products, range check ----------------
  logic [XW-1:0]          xyz [3];
  logic signed [RP_W-1:0] prod1_d [3][3];
  logic signed [RP_W-1:0] prod1_q [3][3];
  logic [2*SW-1:0]        ls1_d, ls1_q;
  logic                   err1_d, err1_q, mode1_q;
  logic [HW-1:0]          h1_q;
  logic [SW-1:0]          s1_q, l1_q;

  assign xyz[0] = req_i.in_x;
  assign xyz[1] = req_i.in_y;
  assign xyz[2] = req_i.in_z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        prod1_d[i][j] = RP_W'(TO_RGB[i][j]) * RP_W'($signed({1'b0, xyz[j]}));
      end
    end
    ls1_d  = (2*SW)'(req_i.in_light) * (2*SW)'(req_i.in_sat);
    err1_d = (req_i.in_hue > HW'(DEG360)) || (req_i.in_sat > SW'(ONE)) ||
             (req_i.in_light > SW'(ONE));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod1_q <= prod1_d;
      ls1_q   <= ls1_d;
      err1_q  <= err1_d;
      mode1_q <= req_i.mode;
      h1_q    <= req_i.in_hue;
      s1_q    <= req_i.in_sat;
      l1_q    <= req_i.in_light;
    end
  end

  // ---------------- stage 2: clamp channels, ramp values ----------------
  logic [SW-1:0]          c2_d [3], c2_q [3];
  logic [SW-1:0]          t1_2_d, t2_2_d, t1_2_q, t2_2_q;
  logic [HW-1:0]          hu2_d [3], hu2_q [3];
  logic                   mode2_q, err2_q;
  logic signed [RA_W-1:0] acc2, rnd2;
  logic [2*SW-1:0]        lsr2;
  logic [SW-1:0]          ls2;
  logic [SW:0]            t2w2, t1w2, hr2;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc2 = RA_W'(prod1_q[i][0]) + RA_W'(prod1_q[i][1]) + RA_W'(prod1_q[i][2]);
      rnd2 = (acc2 + RA_W'(1 << (CBITS - 1))) >>> CBITS;
      if (acc2 <= 0) begin
        c2_d[i] = '0;
      end else if (rnd2 > RA_W'(ONE)) begin
        c2_d[i] = SW'(ONE);
      end else begin
        c2_d[i] = rnd2[SW-1:0];
      end
    end
    lsr2 = ls1_q + (2*SW)'(ONE / 2);
    ls2  = lsr2[FRAC_BITS +: SW];
    if (l1_q <= SW'(ONE / 2)) begin
      t2w2 = {1'b0, l1_q} + {1'b0, ls2};
    end else begin
      t2w2 = {1'b0, l1_q} + {1'b0, s1_q} - {1'b0, ls2};
    end
    t2_2_d = t2w2[SW-1:0];
    t1w2   = {l1_q, 1'b0} - {1'b0, t2_2_d};
    t1_2_d = t1w2[SW-1:0];
    // Wrap the three channel hues into [0,360)
    hr2 = {1'b0, h1_q} + (HW+1)'(2 * DEG60);
    if (hr2 >= (HW+1)'(DEG360)) begin
      hr2 = hr2 - (HW+1)'(DEG360);
    end
    hu2_d[0] = hr2[HW-1:0];
    hu2_d[1] = (h1_q >= HW'(DEG360)) ? h1_q - HW'(DEG360) : h1_q;
    hu2_d[2] = (h1_q < HW'(2 * DEG60)) ? h1_q + HW'(4 * DEG60) : h1_q - HW'(2 * DEG60);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c2_q    <= c2_d;
      t1_2_q  <= t1_2_d;
      t2_2_q  <= t2_2_d;
      hu2_q   <= hu2_d;
      mode2_q <= mode1_q;
      err2_q  <= err1_q;
    end
  end

  // ---------------- stage 3: extremes, sector, ramp cases ----------------
  logic [SW-1:0]     mx3, mn3, a3, b3;
  logic [SW:0]       sum3, sum3p;
  logic [SW:0]       den3w;
  logic [SW-1:0]     light3_d, delta3_d, den3_d, mag3_d;
  logic              gray3_d, neg3_d;
  hxc_sect_e         sect3_d;
  logic [DIV_NW-1:0] snum3_d;
  logic [SW-1:0]     d3_d;
  logic [HW-1:0]     argw3;
  logic [DEG60_W-1:0] arg3_d [3];
  hxc_ramp_e         sel3_d [3];

  logic [SW-1:0]      light3_q, delta3_q, den3_q, mag3_q, d3_q, t1_3_q, t2_3_q;
  logic               gray3_q, neg3_q, mode3_q, err3_q;
  hxc_sect_e          sect3_q;
  logic [DIV_NW-1:0]  snum3_q;
  logic [DEG60_W-1:0] arg3_q [3];
  hxc_ramp_e          sel3_q [3];

  always_comb begin
    mx3 = c2_q[0];
    mn3 = c2_q[0];
    for (int i = 1; i < 3; i++) begin
      if (c2_q[i] > mx3) mx3 = c2_q[i];
      if (c2_q[i] < mn3) mn3 = c2_q[i];
    end
    sum3     = {1'b0, mx3} + {1'b0, mn3};
    sum3p    = sum3 + (SW+1)'(1);
    light3_d = sum3p[SW:1];
    gray3_d  = (mx3 == mn3);
    delta3_d = mx3 - mn3;
    den3w    = (sum3 <= (SW+1)'(ONE)) ? sum3 : (SW+1)'(2 * ONE) - sum3;
    den3_d   = den3w[SW-1:0];
    // Red wins ties over green, green over blue
    if (c2_q[0] == mx3) begin
      sect3_d = SECT_RED;
      a3 = c2_q[1];
      b3 = c2_q[2];
    end else if (c2_q[1] == mx3) begin
      sect3_d = SECT_GREEN;
      a3 = c2_q[2];
      b3 = c2_q[0];
    end else begin
      sect3_d = SECT_BLUE;
      a3 = c2_q[0];
      b3 = c2_q[1];
    end
    neg3_d  = (a3 < b3);
    mag3_d  = neg3_d ? b3 - a3 : a3 - b3;
    snum3_d = (DIV_NW'(delta3_d) << FRAC_BITS) + DIV_NW'(den3_d >> 1);
    // Classify each channel hue on the ramp
    d3_d = t2_2_q - t1_2_q;
    for (int i = 0; i < 3; i++) begin
      if (hu2_q[i] < HW'(DEG60)) begin
        sel3_d[i] = RAMP_RISE;
        argw3     = hu2_q[i];
      end else if (hu2_q[i] < HW'(3 * DEG60)) begin
        sel3_d[i] = RAMP_HIGH;
        argw3     = '0;
      end else if (hu2_q[i] < HW'(4 * DEG60)) begin
        sel3_d[i] = RAMP_RISE;
        argw3     = HW'(4 * DEG60) - hu2_q[i];
      end else begin
        sel3_d[i] = RAMP_LOW;
        argw3     = '0;
      end
      arg3_d[i] = argw3[DEG60_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      light3_q <= light3_d;
      delta3_q <= delta3_d;
      den3_q   <= den3_d;
      mag3_q   <= mag3_d;
      gray3_q  <= gray3_d;
      neg3_q   <= neg3_d;
      sect3_q  <= sect3_d;
      snum3_q  <= snum3_d;
      d3_q     <= d3_d;
      arg3_q   <= arg3_d;
      sel3_q   <= sel3_d;
      t1_3_q   <= t1_2_q;
      t2_3_q   <= t2_2_q;
      mode3_q  <= mode2_q;
      err3_q   <= err2_q;
    end
  end

  // ---------------- stage 4: dividend and ramp products ----------------
  logic [DIV_NW-1:0] num4_d [LANES], num4_q [LANES];
  logic [DIV_DW-1:0] den4_d [LANES], den4_q [LANES];
  logic [CP_W-1:0]   chp4_d [3], chp4_q [3];
  logic [SW-1:0]     t1_4_q, t2_4_q;
  hxc_ramp_e         sel4_q [3];
  hxc_mid_t          mid4_d, mid4_q;

  always_comb begin
    num4_d[LANE_SAT] = snum3_q;
    den4_d[LANE_SAT] = DIV_DW'(den3_q);
    num4_d[LANE_HUE] = DIV_NW'(mag3_q) * DIV_NW'(DEG60) + DIV_NW'(delta3_q >> 1);
    den4_d[LANE_HUE] = DIV_DW'(delta3_q);
    for (int i = 0; i < 3; i++) begin
      chp4_d[i] = CP_W'(d3_q) * CP_W'(arg3_q[i]) + CP_W'(DEG60 / 2);
    end
    mid4_d.mode        = mode3_q;
    mid4_d.range_error = err3_q;
    mid4_d.gray        = gray3_q;
    mid4_d.sector      = sect3_q;
    mid4_d.neg         = neg3_q;
    mid4_d.light       = light3_q;
    mid4_d.ch0         = '0;
    mid4_d.ch1         = '0;
    mid4_d.ch2         = '0;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num4_q <= num4_d;
      den4_q <= den4_d;
      chp4_q <= chp4_d;
      t1_4_q <= t1_3_q;
      t2_4_q <= t2_3_q;
      sel4_q <= sel3_q;
      mid4_q <= mid4_d;
    end
  end

  // ---------------- stage 5: ramp quotients, channel values ----------------
  logic [RCP_PW-1:0] rp5 [3];
  logic [SW-1:0]     rq5 [3], ch5 [3];
  logic [DIV_NW-1:0] num5_q [LANES];
  logic [DIV_DW-1:0] den5_q [LANES];
  hxc_mid_t          mid5_d, mid5_q;

  always_comb begin
    mid5_d = mid4_q;
    for (int i = 0; i < 3; i++) begin
      // Drop the power of two, then divide by 15 through the reciprocal
      rp5[i] = RCP_PW'(chp4_q[i][CP_W-1:RCP_PRE]) * RCP_PW'(RCP_MUL);
      rq5[i] = rp5[i][RCP_SH +: SW];
      case (sel4_q[i])
        RAMP_RISE: ch5[i] = t1_4_q + rq5[i];
        RAMP_HIGH: ch5[i] = t2_4_q;
        default:   ch5[i] = t1_4_q;
      endcase
    end
    mid5_d.ch0 = ch5[0];
    mid5_d.ch1 = ch5[1];
    mid5_d.ch2 = ch5[2];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num5_q <= num4_q;
      den5_q <= den4_q;
      mid5_q <= mid5_d;
    end
  end

  assign valid_o = v5_q;
  assign mid_o   = mid5_q;
  assign num_o   = num5_q;
  assign den_o   = den5_q;

endmodule
`default_nettype wire

// ----- rtl/hxc_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hxc_div
// Pipelined restoring divider, one quotient bit per stage, several lanes
// sharing one valid chain and one context word.
// ----------------------------------------------------------------------------
module hxc_div import hxc_pkg::*; #(
  parameter int NUM_W  = DIV_NW,
  parameter int DEN_W  = DIV_DW,
  parameter int LANE_N = LANES,
  parameter int PAY_W  = $bits(hxc_mid_t)
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               en_i,
  input  wire               valid_i,
  input  wire [NUM_W-1:0]   num_i [LANE_N],
  input  wire [DEN_W-1:0]   den_i [LANE_N],
  input  wire [PAY_W-1:0]   pay_i,
  output logic              valid_o,
  output logic [NUM_W-1:0]  quo_o [LANE_N],
  output logic [PAY_W-1:0]  pay_o
);

  logic [DEN_W-1:0] rem_q [NUM_W][LANE_N];
  logic [DEN_W-1:0] dv_q  [NUM_W][LANE_N];
  logic [NUM_W-1:0] quo_q [NUM_W][LANE_N];
  logic [NUM_W-1:0] sh_q  [NUM_W][LANE_N];
  logic [PAY_W-1:0] pay_q [NUM_W];
  logic [NUM_W-1:0] vld_q;

  for (genvar g = 0; g < NUM_W; g++) begin : g_stage
    logic [DEN_W-1:0] rem_in [LANE_N];
    logic [DEN_W-1:0] dv_in  [LANE_N];
    logic [NUM_W-1:0] quo_in [LANE_N];
    logic [NUM_W-1:0] sh_in  [LANE_N];
    logic [PAY_W-1:0] pay_in;
    logic             v_in;
    logic [DEN_W-1:0] rem_d  [LANE_N];
    logic [NUM_W-1:0] quo_d  [LANE_N];
    logic [NUM_W-1:0] sh_d   [LANE_N];
    logic [DEN_W:0]   trial, diff;
    logic             ge;

    // Select the stage inputs
    if (g == 0) begin : g_first
      always_comb begin
        for (int l = 0; l < LANE_N; l++) begin
          rem_in[l] = '0;
          quo_in[l] = '0;
          sh_in[l]  = num_i[l];
          dv_in[l]  = den_i[l];
        end
        pay_in = pay_i;
        v_in   = valid_i;
      end
    end else begin : g_next
      always_comb begin
        for (int l = 0; l < LANE_N; l++) begin
          rem_in[l] = rem_q[g-1][l];
          quo_in[l] = quo_q[g-1][l];
          sh_in[l]  = sh_q[g-1][l];
          dv_in[l]  = dv_q[g-1][l];
        end
        pay_in = pay_q[g-1];
        v_in   = vld_q[g-1];
      end
    end

    // Shift in one dividend bit, trial subtract
    always_comb begin
      for (int l = 0; l < LANE_N; l++) begin
        trial    = {rem_in[l], sh_in[l][NUM_W-1]};
        diff     = trial - {1'b0, dv_in[l]};
        ge       = (trial >= {1'b0, dv_in[l]});
        rem_d[l] = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        quo_d[l] = {quo_in[l][NUM_W-2:0], ge};
        sh_d[l]  = {sh_in[l][NUM_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g] <= 1'b0;
      end else if (en_i) begin
        vld_q[g] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[g] <= rem_d;
        quo_q[g] <= quo_d;
        sh_q[g]  <= sh_d;
        dv_q[g]  <= dv_in;
        pay_q[g] <= pay_in;
      end
    end
  end

  assign valid_o = vld_q[NUM_W-1];
  assign quo_o   = quo_q[NUM_W-1];
  assign pay_o   = pay_q[NUM_W-1];

endmodule
`default_nettype wire

// ----- rtl/hxc_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hxc_back
// Two stages after the divider: hue assembly, saturation clamp and RGB to
// XYZ products, then the sums and the output register.
// ----------------------------------------------------------------------------
module hxc_back import hxc_pkg::*; (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               en_i,
  input  wire               valid_i,
  input  hxc_mid_t          mid_i,
  input  wire [DIV_NW-1:0]  quo_i [LANES],
  output logic              valid_o,
  output hxc_rsp_t          rsp_o
);

  localparam logic signed [HW+1:0] D360 = (HW+2)'(DEG360);

  logic v1_q, v2_q;

  // Advance the valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  // ---------------- stage 1: hue, saturation, channel products ----------------
  logic signed [HW+1:0] base1, hq1;
  logic [HW-1:0]        qh1, hue1_d, hue1_q;
  logic [SW-1:0]        sat1_d, sat1_q, light1_q;
  logic [SW-1:0]        ch1 [3];
  logic [XP_W-1:0]      xp1_d [3][3], xp1_q [3][3];
  logic                 mode1_q, err1_q;

  assign ch1[0] = mid_i.ch0;
  assign ch1[1] = mid_i.ch1;
  assign ch1[2] = mid_i.ch2;

  always_comb begin
    case (mid_i.sector)
      SECT_RED:   base1 = '0;
      SECT_GREEN: base1 = (HW+2)'(2 * DEG60);
      SECT_BLUE:  base1 = (HW+2)'(4 * DEG60);
      default:    base1 = '0;
    endcase
    qh1 = quo_i[LANE_HUE][HW-1:0];
    hq1 = mid_i.neg ? base1 - $signed({2'b00, qh1}) : base1 + $signed({2'b00, qh1});
    if (hq1 < 0) begin
      hq1 = hq1 + D360;
    end else if (hq1 >= D360) begin
      hq1 = hq1 - D360;
    end
    if (quo_i[LANE_SAT] > DIV_NW'(ONE)) begin
      sat1_d = SW'(ONE);
    end else begin
      sat1_d = quo_i[LANE_SAT][SW-1:0];
    end
    hue1_d = hq1[HW-1:0];
    // Gray has no hue and no saturation
    if (mid_i.gray) begin
      hue1_d = '0;
      sat1_d = '0;
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        xp1_d[i][j] = XP_W'(TO_XYZ[i][j]) * XP_W'(ch1[j]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hue1_q   <= hue1_d;
      sat1_q   <= sat1_d;
      light1_q <= mid_i.light;
      xp1_q    <= xp1_d;
      mode1_q  <= mid_i.mode;
      err1_q   <= mid_i.range_error;
    end
  end

  // ---------------- stage 2: XYZ sums, output register ----------------
  logic [XA_W-1:0] acc2, rnd2;
  logic [XW-1:0]   xyz2 [3];
  hxc_rsp_t        rsp2_d, rsp2_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc2 = XA_W'(xp1_q[i][0]) + XA_W'(xp1_q[i][1]) + XA_W'(xp1_q[i][2]);
      rnd2 = (acc2 + XA_W'(1 << (CBITS - 1))) >> CBITS;
      xyz2[i] = (rnd2 > XA_W'(XMAX)) ? XW'(XMAX) : rnd2[XW-1:0];
    end
    rsp2_d = '0;
    if (!mode1_q) begin
      rsp2_d.out_hue   = hue1_q;
      rsp2_d.out_sat   = sat1_q;
      rsp2_d.out_light = light1_q;
    end else if (err1_q) begin
      rsp2_d.range_error = 1'b1;
    end else begin
      rsp2_d.out_x = xyz2[0];
      rsp2_d.out_y = xyz2[1];
      rsp2_d.out_z = xyz2[2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rsp2_q <= rsp2_d;
    end
  end

  assign valid_o = v2_q;
  assign rsp_o   = rsp2_q;

endmodule
`default_nettype wire

// ----- rtl/hsl_xyz_color_converter_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Datapath: the front stages, then the divider with one quotient bit per stage,
//   then the back stages.
// Throughput: one request per cycle; a stalled output holds the whole pipeline.
// Reset: asynchronous, active low; clears every valid bit, payload is not reset.
// ----------------------------------------------------------------------------
// hsl_xyz_color_converter_top
// Converts CIE XYZ to HSL (mode 0) or HSL to CIE XYZ (mode 1), one result
// per request, through a fully pipelined datapath.
// ----------------------------------------------------------------------------
module hsl_xyz_color_converter_top import hxc_pkg::*; (
  input  wire       clk_i,
  input  wire       rst_ni,
  input  wire       in_valid_i,
  output logic      in_stall_o,
  input  hxc_req_t  in_req_i,
  output logic      out_valid_o,
  input  wire       out_stall_i,
  output hxc_rsp_t  out_rsp_o
);

  logic              en;
  logic              f_valid, d_valid;
  hxc_mid_t          f_mid, d_mid;
  logic [DIV_NW-1:0] f_num [LANES];
  logic [DIV_DW-1:0] f_den [LANES];
  logic [DIV_NW-1:0] d_quo [LANES];

  // Hold every stage while a result waits downstream
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  hxc_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .req_i   (in_req_i),
    .valid_o (f_valid),
    .mid_o   (f_mid),
    .num_o   (f_num),
    .den_o   (f_den)
  );

  hxc_div #(
    .NUM_W  (DIV_NW),
    .DEN_W  (DIV_DW),
    .LANE_N (LANES),
    .PAY_W  ($bits(hxc_mid_t))
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (f_valid),
    .num_i   (f_num),
    .den_i   (f_den),
    .pay_i   (f_mid),
    .valid_o (d_valid),
    .quo_o   (d_quo),
    .pay_o   (d_mid)
  );

  hxc_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (d_valid),
    .mid_i   (d_mid),
    .quo_i   (d_quo),
    .valid_o (out_valid_o),
    .rsp_o   (out_rsp_o)
  );

  // An error result carries no color
  a_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.range_error |->
      out_rsp_o.out_x == '0 && out_rsp_o.out_y == '0 && out_rsp_o.out_z == '0 &&
      out_rsp_o.out_hue == '0)
    else $error("range error result carries color data");

  // Hue stays wrapped below a full turn
  a_hue_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_rsp_o.out_hue < HW'(DEG360))
    else $error("hue not wrapped");

  // Saturation and lightness never exceed one
  a_sl_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_rsp_o.out_sat <= SW'(ONE) && out_rsp_o.out_light <= SW'(ONE))
    else $error("saturation or lightness beyond one");

  // HSL results and XYZ results never mix
  a_mode_split: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_rsp_o.out_light != '0) |->
      out_rsp_o.out_x == '0 && out_rsp_o.out_y == '0 && out_rsp_o.out_z == '0)
    else $error("mixed mode result");

endmodule
`default_nettype wire

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks the HSL / XYZ color converter against a fixed-point color model:
// directed corners of both modes, then random XYZ and HSL requests, with
// random idling on both channels and a scoreboard of expected colors.
// ----------------------------------------------------------------------------
module tb;
  import hxc_pkg::*;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  hxc_req_t in_req = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  hxc_rsp_t out_rsp;

  hxc_rsp_t color_q[$];
  int       n_err = 0;
  int       cycles = 0;
  bit       calm = 1'b0;

  hsl_xyz_color_converter_top dut (
    .clk_i(clk), .rst_ni(rst_n), .in_valid_i(in_valid), .in_stall_o(in_stall),
    .in_req_i(in_req), .out_valid_o(out_valid), .out_stall_i(out_stall),
    .out_rsp_o(out_rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Round a Q16 channel sum and clamp it to [0, 1.0]
  function automatic longint clamp_chan(longint v);
    longint r;
    if (v <= 0) return 0;
    r = (v + (64'sd1 << (CBITS - 1))) >>> CBITS;
    return (r > ONE) ? ONE : r;
  endfunction

  // Evaluate the hue ramp between the two ramp values
  function automatic longint hue_ramp(longint t1, longint t2, longint h);
    longint d;
    d = t2 - t1;
    if (h >= DEG360) h -= DEG360;
    if (h < 0) h += DEG360;
    if (h < DEG60) return t1 + (d * h + DEG60 / 2) / DEG60;
    if (h < 3 * DEG60) return t2;
    if (h < 4 * DEG60) return t1 + (d * (4 * DEG60 - h) + DEG60 / 2) / DEG60;
    return t1;
  endfunction

  function automatic hxc_rsp_t convert_color(hxc_req_t r);
    hxc_rsp_t o;
    longint c[3], mx, mn, sum, delta, den, q, num, mag, hq, h, s, l, ls, t1, t2, acc;
    int sector;
    o = '0;
    if (!r.mode) begin
      for (int i = 0; i < 3; i++)
        c[i] = clamp_chan(TO_RGB[i][0] * longint'(r.in_x) + TO_RGB[i][1] * longint'(r.in_y)
                          + TO_RGB[i][2] * longint'(r.in_z));
      mx = c[0]; mn = c[0];
      for (int i = 1; i < 3; i++) begin
        if (c[i] > mx) mx = c[i];
        if (c[i] < mn) mn = c[i];
      end
      sum = mx + mn;
      o.out_light = SW'((sum + 1) >> 1);
      if (mx != mn) begin
        delta = mx - mn;
        den = (sum <= ONE) ? sum : 2 * ONE - sum;
        q = ((delta << FRAC_BITS) + den / 2) / den;
        o.out_sat = SW'((q > ONE) ? ONE : q);
        if (c[0] == mx) begin sector = 0; num = c[1] - c[2]; end
        else if (c[1] == mx) begin sector = 2; num = c[2] - c[0]; end
        else begin sector = 4; num = c[0] - c[1]; end
        mag = (num < 0) ? -num : num;
        q = (mag * DEG60 + delta / 2) / delta;
        hq = sector * DEG60;
        hq = (num < 0) ? hq - q : hq + q;
        if (hq < 0) hq += DEG360;
        if (hq >= DEG360) hq -= DEG360;
        o.out_hue = HW'(hq);
      end
    end else begin
      h = r.in_hue; s = r.in_sat; l = r.in_light;
      if (h > DEG360 || s > ONE || l > ONE) begin
        o.range_error = 1'b1;
      end else begin
        ls = (l * s + (ONE >> 1)) >> FRAC_BITS;
        t2 = (l <= (ONE >> 1)) ? l + ls : l + s - ls;
        t1 = 2 * l - t2;
        c[0] = hue_ramp(t1, t2, h + 2 * DEG60);
        c[1] = hue_ramp(t1, t2, h);
        c[2] = hue_ramp(t1, t2, h - 2 * DEG60);
        for (int i = 0; i < 3; i++) begin
          acc = TO_XYZ[i][0] * c[0] + TO_XYZ[i][1] * c[1] + TO_XYZ[i][2] * c[2];
          acc = (acc + (64'sd1 << (CBITS - 1))) >>> CBITS;
          if (acc > XMAX) acc = XMAX;
          if (i == 0) o.out_x = XW'(acc);
          else if (i == 1) o.out_y = XW'(acc);
          else o.out_z = XW'(acc);
        end
      end
    end
    return o;
  endfunction

  function automatic bit roll_idle();
    return !calm && ($urandom_range(99) < 20);
  endfunction

  // Send one request, idling at random beforehand; called right after a rising edge
  task automatic send_color(hxc_req_t r);
    while (roll_idle()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= r;
    do @(posedge clk); while (in_stall);
    color_q.push_back(convert_color(r));
  endtask

  function automatic hxc_req_t xyz_req(int x, int y, int z);
    hxc_req_t r;
    r.in_hue = HW'($urandom()); r.in_sat = SW'($urandom()); r.in_light = SW'($urandom());
    r.mode = 1'b0; r.in_x = XW'(x); r.in_y = XW'(y); r.in_z = XW'(z);
    return r;
  endfunction

  function automatic hxc_req_t hsl_req(int h, int s, int l);
    hxc_req_t r;
    r.in_x = XW'($urandom()); r.in_y = XW'($urandom()); r.in_z = XW'($urandom());
    r.mode = 1'b1; r.in_hue = HW'(h); r.in_sat = SW'(s); r.in_light = SW'(l);
    return r;
  endfunction

  // Randomize the output stall each cycle
  always @(posedge clk) begin
    cycles <= cycles + 1;
    out_stall <= roll_idle();
  end

  // Compare each accepted result with the oldest expected color
  always @(posedge clk) begin
    hxc_rsp_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (color_q.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("unexpected result %h", out_rsp);
      end else begin
        e = color_q.pop_front();
        if (out_rsp !== e) begin
          n_err++;
          if (n_err <= 10)
            $display("mismatch: exp hue %0d sat %0d light %0d x %0d y %0d z %0d err %0b",
                     e.out_hue, e.out_sat, e.out_light, e.out_x, e.out_y, e.out_z,
                     e.range_error, " / got hue %0d sat %0d light %0d x %0d y %0d z %0d err %0b",
                     out_rsp.out_hue, out_rsp.out_sat, out_rsp.out_light, out_rsp.out_x,
                     out_rsp.out_y, out_rsp.out_z, out_rsp.range_error);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > 400000) begin
      $display("tb failed");
      $finish;
    end
  end

  task automatic test_xyz_corners();
    send_color(xyz_req(0, 0, 0));
    send_color(xyz_req(XMAX, XMAX, XMAX));
    send_color(xyz_req(XMAX, 0, 0));
    send_color(xyz_req(0, XMAX, 0));
    send_color(xyz_req(0, 0, XMAX));
    send_color(xyz_req(31130, 32768, 35680));
    send_color(xyz_req(13513, 6968, 634));
    send_color(xyz_req(11719, 23438, 3906));
    send_color(xyz_req(5905, 2362, 31100));
    send_color(xyz_req(25000, 12000, 40000));
  endtask

  task automatic test_hsl_corners();
    send_color(hsl_req(0, 0, 0));
    send_color(hsl_req(DEG360, ONE, ONE));
    send_color(hsl_req(DEG360 + 1, 0, 0));
    send_color(hsl_req(0, ONE + 1, 0));
    send_color(hsl_req(0, 0, ONE + 1));
    send_color(hsl_req(32767, 65535, 65535));
    send_color(hsl_req(100 * 64, 0, 20000));
    send_color(hsl_req(0, ONE, ONE / 2));
    send_color(hsl_req(DEG60, ONE, ONE / 2 + 1));
    send_color(hsl_req(3 * DEG60 + 5, 20000, 10000));
    send_color(hsl_req(4 * DEG60, 30000, 25000));
    send_color(hsl_req(DEG360 - 1, ONE, 1));
  endtask

  task automatic test_random(int n);
    hxc_req_t r;
    for (int i = 0; i < n; i++) begin
      calm = (i >= n / 2) && (i < n / 2 + 60);
      if ($urandom_range(1)) begin
        if ($urandom_range(9) == 0) r = xyz_req($urandom(), $urandom(), $urandom());
        else r = xyz_req($urandom_range(40000), $urandom_range(40000),
                         $urandom_range(45000));
      end else begin
        if ($urandom_range(9) == 0) r = hsl_req($urandom(), $urandom(), $urandom());
        else r = hsl_req($urandom_range(DEG360), $urandom_range(ONE),
                         $urandom_range(ONE));
      end
      send_color(r);
    end
    calm = 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_xyz_corners();
    test_hsl_corners();
    test_random(430);
    in_valid <= 1'b0;
    while (color_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (n_err == 0) $display("tb passed");
    else $display("tb failed");
    $finish;
  end
endmodule
